[hdl/rc_ook_pkg.sv]
package rc_ook_pkg;

  localparam int WORD_BITS = 12;
  localparam int BIT_POS_W = 4;
  localparam int UNITS_W = 5;
  localparam int TICKS_W = 15;
  localparam int REPEAT_W = 8;
  localparam int SYS_W = 5;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = BIT_POS_W'(WORD_BITS - 1);
  localparam logic [UNITS_W-1:0] SHORT_UNITS = UNITS_W'(1);
  localparam logic [UNITS_W-1:0] LONG_UNITS = UNITS_W'(3);
  localparam logic [UNITS_W-1:0] SYNC_LOW_UNITS = UNITS_W'(31);

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYSTEM_CODE = 2'd0,
    CFG_REPEAT_COUNT = 2'd1,
    CFG_PULSE_LENGTH = 2'd2
  } cfg_idx_t;

  // line segment of the frame
  typedef enum logic [2:0] {
    SEG_LEAD_HI = 3'd0,
    SEG_LEAD_LO = 3'd1,
    SEG_DATA_HI = 3'd2,
    SEG_DATA_LO = 3'd3,
    SEG_SYNC_HI = 3'd4,
    SEG_SYNC_LO = 3'd5
  } seg_t;

  typedef struct packed {
    logic       op;
    logic [4:0] device_address;
    logic       switch_on;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic done_res;
  } out_item_t;

endpackage

[hdl/rc_tristate_ook_encoder_core.sv]
// Tristate on-off-keyed remote-control encoder. A start transfer (op = 1) builds the 12-bit
// code word {system_code, device_address, on/off pair} and, when idle and repeat_count is
// nonzero, begins sending the frame repeat_count times; a start while busy is ignored. Every
// tick transfer (op = 0) is one microsecond of line time and returns the line level for that
// tick, a busy flag, and a done flag on the tick that ends the last frame. Each bit is sent
// MSB first as high 1 / low 3 units followed by high 1 / low 3 (bit set) or high 3 / low 1
// (bit clear); each frame ends with a sync of high 1 / low 31 units; one unit is
// pulse_length ticks (0 counts as 1). Every input transfer yields exactly one result. The
// block takes one item per clock: the whole step is done in the cycle of the input transfer
// and lands in a single result register, and a new item is taken whenever that register is
// empty or being drained in the same cycle. pulse_length is read live at each unit start;
// repeat_count and system_code are sampled at start. Configuration writes take effect at
// the next clock edge.
module rc_tristate_ook_encoder_core
  import rc_ook_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [SYS_W-1:0]    system_code_r;
  logic [REPEAT_W-1:0] repeat_count_r;
  logic [TICKS_W-1:0]  pulse_length_r;

  // encoder state
  logic [WORD_BITS-1:0] code_word_r, code_word_nxt;
  logic [REPEAT_W-1:0]  repeats_left_r, repeats_left_nxt;
  logic [BIT_POS_W-1:0] bit_pos_r, bit_pos_nxt;
  seg_t                 seg_r, seg_nxt;
  logic [UNITS_W-1:0]   units_left_r, units_left_nxt;
  logic [TICKS_W-1:0]   ticks_left_r, ticks_left_nxt;
  logic                 active_r, active_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic               in_xfer;
  logic [TICKS_W-1:0] unit_ticks;
  logic               cur_bit;
  logic [TICKS_W-1:0] ticks_dec;
  logic [UNITS_W-1:0] units_dec;
  logic               start_ok;

  // result slot frees up when empty or drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a zero pulse length behaves as one tick per unit
  assign unit_ticks = (pulse_length_r == '0) ? TICKS_W'(1) : pulse_length_r;
  assign cur_bit    = code_word_r[bit_pos_r];
  assign ticks_dec  = ticks_left_r - TICKS_W'(1);
  assign units_dec  = units_left_r - UNITS_W'(1);
  assign start_ok   = !active_r && (repeat_count_r != '0);

  // line is high during the lead, data and sync high segments
  function automatic logic seg_is_high(input seg_t s);
    logic hi;
    unique case (s)
      SEG_LEAD_HI, SEG_DATA_HI, SEG_SYNC_HI: hi = 1'b1;
      default:                               hi = 1'b0;
    endcase
    return hi;
  endfunction

  // one encoder step per input transfer
  always_comb begin
    code_word_nxt    = code_word_r;
    repeats_left_nxt = repeats_left_r;
    bit_pos_nxt      = bit_pos_r;
    seg_nxt          = seg_r;
    units_left_nxt   = units_left_r;
    ticks_left_nxt   = ticks_left_r;
    active_nxt       = active_r;
    out_data_nxt     = out_data_r;

    if (in_xfer) begin
      out_data_nxt = '0;
      if (in_data.op == OP_START) begin
        if (start_ok) begin
          code_word_nxt    = {system_code_r, in_data.device_address,
                              in_data.switch_on, !in_data.switch_on};
          repeats_left_nxt = repeat_count_r;
          bit_pos_nxt      = LAST_BIT_POS;
          active_nxt       = 1'b1;
          seg_nxt          = SEG_LEAD_HI;
          units_left_nxt   = SHORT_UNITS;
          ticks_left_nxt   = unit_ticks;
        end
        // no time passes on a start: report the level now held
        out_data_nxt.line_level = start_ok ? 1'b1 : (active_r && seg_is_high(seg_r));
        out_data_nxt.busy_res   = start_ok || active_r;
      end else if (active_r) begin
        out_data_nxt.line_level = seg_is_high(seg_r);
        out_data_nxt.busy_res   = 1'b1;
        ticks_left_nxt          = ticks_dec;
        if (ticks_dec == '0) begin
          units_left_nxt = units_dec;
          if (units_dec != '0) begin
            ticks_left_nxt = unit_ticks;
          end else begin
            // segment finished, move on
            ticks_left_nxt = unit_ticks;
            unique case (seg_r)
              SEG_LEAD_HI: begin
                seg_nxt        = SEG_LEAD_LO;
                units_left_nxt = LONG_UNITS;
              end
              SEG_LEAD_LO: begin
                seg_nxt        = SEG_DATA_HI;
                units_left_nxt = cur_bit ? SHORT_UNITS : LONG_UNITS;
              end
              SEG_DATA_HI: begin
                seg_nxt        = SEG_DATA_LO;
                units_left_nxt = cur_bit ? LONG_UNITS : SHORT_UNITS;
              end
              SEG_DATA_LO: begin
                units_left_nxt = SHORT_UNITS;
                if (bit_pos_r == '0) begin
                  seg_nxt = SEG_SYNC_HI;
                end else begin
                  seg_nxt     = SEG_LEAD_HI;
                  bit_pos_nxt = bit_pos_r - BIT_POS_W'(1);
                end
              end
              SEG_SYNC_HI: begin
                seg_nxt        = SEG_SYNC_LO;
                units_left_nxt = SYNC_LOW_UNITS;
              end
              default: begin
                // end of sync low: frame done
                repeats_left_nxt = repeats_left_r - REPEAT_W'(1);
                bit_pos_nxt      = LAST_BIT_POS;
                seg_nxt          = SEG_LEAD_HI;
                if (repeats_left_r == REPEAT_W'(1)) begin
                  active_nxt            = 1'b0;
                  units_left_nxt        = '0;
                  ticks_left_nxt        = '0;
                  out_data_nxt.done_res = 1'b1;
                end else begin
                  units_left_nxt = SHORT_UNITS;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      system_code_r  <= '0;
      repeat_count_r <= REPEAT_W'(10);
      pulse_length_r <= TICKS_W'(350);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYSTEM_CODE:  system_code_r  <= cfg_wdata[SYS_W-1:0];
        CFG_REPEAT_COUNT: repeat_count_r <= cfg_wdata[REPEAT_W-1:0];
        CFG_PULSE_LENGTH: pulse_length_r <= cfg_wdata[TICKS_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // encoder state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_word_r    <= '0;
      repeats_left_r <= '0;
      bit_pos_r      <= LAST_BIT_POS;
      seg_r          <= SEG_LEAD_HI;
      units_left_r   <= '0;
      ticks_left_r   <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      code_word_r    <= code_word_nxt;
      repeats_left_r <= repeats_left_nxt;
      bit_pos_r      <= bit_pos_nxt;
      seg_r          <= seg_nxt;
      units_left_r   <= units_left_nxt;
      ticks_left_r   <= ticks_left_nxt;
      active_r       <= active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[bench/rc_tristate_ook_encoder_core_test.sv]
`timescale 1ns / 1ps

module rc_tristate_ook_encoder_core_test;
  import rc_ook_pkg::*;

  // index with no register behind it, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // tracks the encoder line state and holds the line samples still owed by the block
  class ook_line_tracker;
    logic [SYS_W-1:0]     sys_code;
    logic [REPEAT_W-1:0]  rep_count;
    logic [TICKS_W-1:0]   pulse_len;
    logic [WORD_BITS-1:0] code_word;
    logic [REPEAT_W-1:0]  repeats_left;
    logic [BIT_POS_W-1:0] bit_pos;
    seg_t                 seg;
    logic [UNITS_W-1:0]   units_left;
    logic [TICKS_W-1:0]   ticks_left;
    bit                   active;
    out_item_t            line_forecast[$];
    int                   errors;

    function new();
      sys_code = '0;
      rep_count = REPEAT_W'(10);
      pulse_len = TICKS_W'(350);
      code_word = '0;
      repeats_left = '0;
      bit_pos = LAST_BIT_POS;
      seg = SEG_LEAD_HI;
      units_left = '0;
      ticks_left = '0;
      active = 1'b0;
      errors = 0;
    endfunction

    function int depth();
      return line_forecast.size();
    endfunction

    // a pulse length of zero still lasts one tick
    function logic [TICKS_W-1:0] unit_len();
      return (pulse_len == '0) ? TICKS_W'(1) : pulse_len;
    endfunction

    function void enter(seg_t s, logic [UNITS_W-1:0] u);
      seg = s;
      units_left = u;
      ticks_left = unit_len();
    endfunction

    function logic level_now();
      return active && (seg == SEG_LEAD_HI || seg == SEG_DATA_HI || seg == SEG_SYNC_HI);
    endfunction

    // next segment, returns 1 when the last frame has ended
    function logic advance();
      case (seg)
        SEG_LEAD_HI: enter(SEG_LEAD_LO, LONG_UNITS);
        SEG_LEAD_LO: enter(SEG_DATA_HI, code_word[bit_pos] ? SHORT_UNITS : LONG_UNITS);
        SEG_DATA_HI: enter(SEG_DATA_LO, code_word[bit_pos] ? LONG_UNITS : SHORT_UNITS);
        SEG_DATA_LO: begin
          if (bit_pos == '0) begin
            enter(SEG_SYNC_HI, SHORT_UNITS);
          end else begin
            bit_pos = bit_pos - 1'b1;
            enter(SEG_LEAD_HI, SHORT_UNITS);
          end
        end
        SEG_SYNC_HI: enter(SEG_SYNC_LO, SYNC_LOW_UNITS);
        default: begin
          repeats_left = repeats_left - 1'b1;
          bit_pos = LAST_BIT_POS;
          if (repeats_left == '0) begin
            active = 1'b0;
            seg = SEG_LEAD_HI;
            units_left = '0;
            ticks_left = '0;
            return 1'b1;
          end
          enter(SEG_LEAD_HI, SHORT_UNITS);
        end
      endcase
      return 1'b0;
    endfunction

    function out_item_t encode_step(in_item_t item);
      out_item_t r;
      r = '0;
      if (item.op == OP_START) begin
        // a start while sending, or with no repeats, leaves everything as it is
        if (!active && rep_count != '0) begin
          code_word = {sys_code, item.device_address, 2'b00} | (WORD_BITS'(1) << item.switch_on);
          repeats_left = rep_count;
          bit_pos = LAST_BIT_POS;
          active = 1'b1;
          enter(SEG_LEAD_HI, SHORT_UNITS);
        end
        r.line_level = level_now();
        r.busy_res = active;
      end else if (active) begin
        r.line_level = level_now();
        r.busy_res = 1'b1;
        ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) begin
          units_left = units_left - 1'b1;
          if (units_left == '0) begin
            r.done_res = advance();
          end else begin
            ticks_left = unit_len();
          end
        end
      end
      return r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SYSTEM_CODE: sys_code = data[SYS_W-1:0];
        CFG_REPEAT_COUNT: rep_count = data[REPEAT_W-1:0];
        CFG_PULSE_LENGTH: pulse_len = data[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t item);
      line_forecast.push_back(encode_step(item));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (line_forecast.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %b", $time, got);
        return;
      end
      want = line_forecast.pop_front();
      if (got.line_level !== want.line_level) begin
        errors++;
        $display("%0t: line_level expected %b actual %b", $time, want.line_level,
                 got.line_level);
      end
      if (got.busy_res !== want.busy_res) begin
        errors++;
        $display("%0t: busy_res expected %b actual %b", $time, want.busy_res, got.busy_res);
      end
      if (got.done_res !== want.done_res) begin
        errors++;
        $display("%0t: done_res expected %b actual %b", $time, want.done_res, got.done_res);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ook_line_tracker tracker;
  int items_sent = 0;
  int results_seen = 0;
  int tx_idle_pct = 0;     // chance in percent of a sender gap before an item
  bit stall_on = 1'b0;     // receiver takes random stall bursts
  int rx_hold = 0;
  bit long_hold_done = 1'b0;

  rc_tristate_ook_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // everything seen at a rising edge: result transfers, input transfers, register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.check_result(out_data);
        results_seen++;
      end
      if (in_valid && in_ready) tracker.note_input(in_data);
      if (cfg_we) tracker.write_reg(cfg_index, cfg_wdata);
    end
  end

  // receiver: random stall bursts, plus one long hold-off while the sender is offering,
  // so the result register stays full and the block has to stall its input side
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150 && in_valid) begin
      long_hold_done = 1'b1;
      rx_hold = 47;
      out_ready <= 1'b0;
    end else if (stall_on && $urandom_range(99) < 12) begin
      rx_hold = $urandom_range(5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t make_item(op_t op);
    in_item_t it;
    it.op = op;
    it.device_address = 5'($urandom_range(31));
    it.switch_on = 1'($urandom_range(1));
    return it;
  endfunction

  // called at a falling edge; holds valid until the transfer happens
  task automatic offer(input in_item_t item);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_item(input in_item_t item);
    @(negedge clk);
    offer(item);
  endtask

  // called at a falling edge; waits until every owed line sample has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.depth() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    drain_results();
  endtask

  // ends at a falling edge with the write enable low again
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // keeps ticking until the transmission is over; stray starts are mixed in and
  // must be ignored; at tick mid_at the registers are rewritten mid-frame
  task automatic run_transmission(input int mid_at);
    int n;
    n = 0;
    forever begin
      @(negedge clk);
      if (!tracker.active) begin
        in_valid <= 1'b0;
        break;
      end
      if (n == mid_at) begin
        drain_results();
        // pulse length is picked up at the next unit, the others only at a start
        write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'($urandom_range(2)));
        write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'($urandom_range(32767)));
        write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'($urandom_range(32767)));
      end
      offer(make_item($urandom_range(9) == 0 ? OP_START : OP_TICK));
      n++;
    end
  endtask

  initial begin
    int r;
    logic [CFG_DATA_W-1:0] w;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks with the fields at both extremes
    send_item(in_item_t'{OP_TICK, 5'd31, 1'b1});
    send_item(in_item_t'{OP_TICK, 5'd0, 1'b0});

    // zero repeats: a start sends nothing
    stop_and_drain();
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(0));
    send_item(in_item_t'{OP_START, 5'd31, 1'b1});
    send_item(in_item_t'{OP_TICK, 5'd31, 1'b1});

    // top system code, zero pulse length, a write to the unused index
    stop_and_drain();
    write_reg(CFG_NO_REG, CFG_DATA_W'(32767));
    write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'(31));
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(1));
    write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'(0));
    send_item(in_item_t'{OP_START, 5'd0, 1'b0});
    // start while busy is dropped
    send_item(in_item_t'{OP_START, 5'd31, 1'b1});
    repeat (6) send_item(make_item(OP_TICK));

    // mid-frame register change
    stop_and_drain();
    write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'(3));
    write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'(0));
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(5));
    repeat (6) send_item(make_item(OP_TICK));

    // random phases: short pulses and few repeats so whole transmissions finish
    while (items_sent < 330) begin
      stop_and_drain();
      r = $urandom_range(2);
      tx_idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 35;
      stall_on = ($urandom_range(3) != 0);
      write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'($urandom_range(32767)));
      w = CFG_DATA_W'($urandom_range(32767));
      r = $urandom_range(9);
      w[REPEAT_W-1:0] = (r == 0) ? 8'd0 : (r < 8) ? 8'd1 : 8'd2;
      write_reg(CFG_REPEAT_COUNT, w);
      r = $urandom_range(9);
      write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'((r < 2) ? 0 : (r < 8) ? 1 : 2));
      if ($urandom_range(7) == 0) write_reg(CFG_NO_REG, CFG_DATA_W'($urandom_range(32767)));
      repeat ($urandom_range(3))
        send_item(make_item($urandom_range(4) == 0 ? OP_START : OP_TICK));
      send_item(make_item(OP_START));
      run_transmission(($urandom_range(3) == 0) ? $urandom_range(100, 10) : -1);
    end

    // no idling: one whole transmission at one tick per unit
    stop_and_drain();
    tx_idle_pct = 0;
    stall_on = 1'b0;
    write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'(0));
    write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'($urandom_range(31)));
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(1));
    send_item(make_item(OP_START));
    run_transmission(-1);
    send_item(make_item(OP_TICK));

    // widest pulse and the most repeats: only the first ticks of the first unit
    stop_and_drain();
    write_reg(CFG_REPEAT_COUNT, CFG_DATA_W'(255));
    write_reg(CFG_PULSE_LENGTH, CFG_DATA_W'(32767));
    write_reg(CFG_SYSTEM_CODE, CFG_DATA_W'($urandom_range(31)));
    send_item(make_item(OP_START));
    repeat (4) send_item(make_item(OP_TICK));

    stop_and_drain();
    repeat (5) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS rc_tristate_ook_encoder_core");
    end else begin
      $display("FAIL rc_tristate_ook_encoder_core");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAIL rc_tristate_ook_encoder_core");
    $finish;
  end

endmodule
